// ===== sv/lmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter ballistics package
// Shared widths, register indexes and word types for the level meter.
// ----------------------------------------------------------------------------
package lmb_pkg;

  localparam int LevelBits = 16;
  localparam int CoefBits  = 16;
  localparam int TickBits  = 8;
  localparam int CfgBits   = 16;
  localparam int CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] RegAttack    = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegRelease   = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegHoldDecay = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegHoldTicks = 2'd3;

  localparam logic [CoefBits-1:0] AttackReset    = 16'd45875;
  localparam logic [CoefBits-1:0] ReleaseReset   = 16'd57672;
  localparam logic [CoefBits-1:0] HoldDecayReset = 16'd64225;
  localparam logic [TickBits-1:0] HoldTicksReset = 8'd30;

  typedef logic [LevelBits-1:0] level_t;
  typedef logic [CoefBits-1:0]  coef_t;

  typedef struct packed {
    level_t peak_level;
    level_t rms_level;
  } lmb_in_t;

  typedef struct packed {
    level_t shown_peak;
    level_t shown_rms;
    level_t held_peak;
  } lmb_out_t;

  typedef struct packed {
    coef_t                attack_coef;
    coef_t                release_coef;
    coef_t                hold_decay_coef;
    logic [TickBits-1:0]  hold_ticks;
  } lmb_cfg_t;

endpackage

// ===== sv/lmb_ballistic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter ballistic smoother
// Holds one shown level and moves it toward the new level by the attack
// fraction when it rises, or scales it by the release factor otherwise.
// ----------------------------------------------------------------------------
module lmb_ballistic
  import lmb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  level_t   level_i,
  input  lmb_cfg_t cfg_i,
  output level_t   next_o
);

  level_t                        shown_q;
  level_t                        shown_d;
  logic                          rise;
  level_t                        operand;
  coef_t                         coef;
  logic [LevelBits+CoefBits-1:0] prod;
  level_t                        scaled;

  // One multiplier serves both cases; the attack step never overshoots the level.
  assign rise    = level_i > shown_q;
  assign operand = rise ? level_t'(level_i - shown_q) : shown_q;
  assign coef    = rise ? cfg_i.attack_coef : cfg_i.release_coef;
  assign prod    = (LevelBits+CoefBits)'(operand) * (LevelBits+CoefBits)'(coef);
  assign scaled  = prod[CoefBits +: LevelBits];
  assign shown_d = rise ? level_t'(shown_q + scaled) : scaled;
  assign next_o  = shown_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= '0;
    end else if (step_i) begin
      shown_q <= shown_d;
    end
  end

endmodule

// ===== sv/lmb_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter peak hold
// Captures any higher peak, keeps it for a programmed number of ticks and
// then lets it decay by the hold-decay factor.
// ----------------------------------------------------------------------------
module lmb_hold
  import lmb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  level_t   peak_i,
  input  lmb_cfg_t cfg_i,
  output level_t   next_o
);

  level_t                        value_q;
  level_t                        value_d;
  logic [TickBits-1:0]           count_q;
  logic [TickBits-1:0]           count_d;
  logic [LevelBits+CoefBits-1:0] prod;

  assign prod = (LevelBits+CoefBits)'(value_q) * (LevelBits+CoefBits)'(cfg_i.hold_decay_coef);

  // A peak equal to the held value does not restart the hold time.
  always_comb begin
    value_d = value_q;
    count_d = count_q;
    if (peak_i > value_q) begin
      value_d = peak_i;
      count_d = cfg_i.hold_ticks;
    end else if (count_q != '0) begin
      count_d = count_q - TickBits'(1);
    end else begin
      value_d = prod[CoefBits +: LevelBits];
    end
  end

  assign next_o = value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      count_q <= '0;
    end else if (step_i) begin
      value_q <= value_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/level_meter_ballistics.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter ballistics
// Top level: input register, per-level smoothing and peak hold, result
// register, and the configuration registers.
// ----------------------------------------------------------------------------
// The meter takes one word per display tick carrying the peak and RMS levels
// (unsigned Q1.15) and returns one word per tick with the shown peak, the
// shown RMS and the held peak after that tick's update. It accepts a word in
// every cycle unless the output stalls; a result passes through the input
// register, then the result register. The rate rests on the 16 x 16 update
// multiplies (one per level, one for the hold decay), whose results feed
// straight back into the shown-level and hold registers. The user must write
// coefficients through the configuration port only while the meter is idle;
// the block does not enforce this. They take effect on the next word.
// ----------------------------------------------------------------------------
module level_meter_ballistics
  import lmb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lmb_in_t               in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lmb_out_t              out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i
);

  lmb_cfg_t cfg_q;
  logic     in_valid_q;
  lmb_in_t  in_word_q;
  logic     out_valid_q;
  lmb_out_t out_word_q;
  lmb_out_t out_word_d;
  logic     advance;
  logic     accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef     <= AttackReset;
      cfg_q.release_coef    <= ReleaseReset;
      cfg_q.hold_decay_coef <= HoldDecayReset;
      cfg_q.hold_ticks      <= HoldTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegAttack:    cfg_q.attack_coef     <= cfg_data_i[CoefBits-1:0];
        RegRelease:   cfg_q.release_coef    <= cfg_data_i[CoefBits-1:0];
        RegHoldDecay: cfg_q.hold_decay_coef <= cfg_data_i[CoefBits-1:0];
        RegHoldTicks: cfg_q.hold_ticks      <= cfg_data_i[TickBits-1:0];
        default: ;
      endcase
    end
  end

  // The update stage moves when it holds a word and the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= out_word_d;
    end
  end

  lmb_ballistic u_peak (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (in_word_q.peak_level),
    .cfg_i   (cfg_q),
    .next_o  (out_word_d.shown_peak)
  );

  lmb_ballistic u_rms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (in_word_q.rms_level),
    .cfg_i   (cfg_q),
    .next_o  (out_word_d.shown_rms)
  );

  lmb_hold u_hold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .peak_i (in_word_q.peak_level),
    .cfg_i  (cfg_q),
    .next_o (out_word_d.held_peak)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== sv/lmb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter ballistics checker
// Port-level checks on flow and result ordering, bound to the top level.
// ----------------------------------------------------------------------------
module lmb_checker
  import lmb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input lmb_out_t              out_word_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // A fresh result only follows an accepted input word.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result word without an accepted input word");

  // With the output draining, the input side never backs up.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output is ready");

endmodule

bind level_meter_ballistics lmb_checker u_lmb_checker (.*);

// ===== tb/level_meter_ballistics_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level meter ballistics testbench
// Drives display ticks through the meter with bursty input and a stalling
// output. An internal model of the smoothing and peak hold predicts every
// result word, and each result is checked in order against that prediction.
// The run covers the reset coefficients, the all-zero and all-ones extremes
// and several random coefficient sets.
// ----------------------------------------------------------------------------
module level_meter_ballistics_tb;
  import lmb_pkg::*;

  class meter_scoreboard;
    coef_t               attack_c;
    coef_t               rel_c;
    coef_t               decay_c;
    logic [TickBits-1:0] ticks;
    level_t              peak_s;
    level_t              rms_s;
    level_t              held;
    logic [TickBits-1:0] count;
    lmb_out_t            expected_q[$];
    int                  errors;
    int                  mismatches;

    function new();
      attack_c   = AttackReset;
      rel_c      = ReleaseReset;
      decay_c    = HoldDecayReset;
      ticks      = HoldTicksReset;
      peak_s     = '0;
      rms_s      = '0;
      held       = '0;
      count      = '0;
      errors     = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] data);
      case (idx)
        RegAttack:    attack_c = data[CoefBits-1:0];
        RegRelease:   rel_c    = data[CoefBits-1:0];
        RegHoldDecay: decay_c  = data[CoefBits-1:0];
        RegHoldTicks: ticks    = data[TickBits-1:0];
        default: ;
      endcase
    endfunction

    // Q1.15 level times Q0.16 coefficient, truncated.
    function level_t scale(level_t v, coef_t c);
      logic [2*LevelBits-1:0] prod;
      prod = {{LevelBits{1'b0}}, v} * {{LevelBits{1'b0}}, c};
      return prod[2*LevelBits-1:LevelBits];
    endfunction

    // A level equal to the shown value falls under release.
    function level_t smooth(level_t shown, level_t lvl);
      if (lvl > shown) return shown + scale(lvl - shown, attack_c);
      return scale(shown, rel_c);
    endfunction

    function void note_word(lmb_in_t w);
      lmb_out_t exp_w;
      peak_s = smooth(peak_s, w.peak_level);
      rms_s  = smooth(rms_s, w.rms_level);
      if (w.peak_level > held) begin
        held  = w.peak_level;
        count = ticks;
      end else if (count > 0) begin
        count = count - 1'b1;
      end else begin
        held = scale(held, decay_c);
      end
      exp_w.shown_peak = peak_s;
      exp_w.shown_rms  = rms_s;
      exp_w.held_peak  = held;
      expected_q.push_back(exp_w);
    endfunction

    function void check_result(lmb_out_t got);
      lmb_out_t exp_w;
      if (expected_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: peak %0d rms %0d held %0d",
                   got.shown_peak, got.shown_rms, got.held_peak);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.shown_peak !== exp_w.shown_peak || got.shown_rms !== exp_w.shown_rms ||
          got.held_peak !== exp_w.held_peak) begin
        errors++;
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected peak %0d rms %0d held %0d, got %0d %0d %0d",
                   exp_w.shown_peak, exp_w.shown_rms, exp_w.held_peak,
                   got.shown_peak, got.shown_rms, got.held_peak);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  lmb_in_t               in_word_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  lmb_out_t              out_word_o;
  logic                  cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgBits-1:0]    cfg_data_i;

  meter_scoreboard sb;
  bit              hold_req;

  // Envelope generator state for the random ticks.
  int     env_mode;
  int     env_left;
  level_t env_target;

  level_meter_ballistics u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_word_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_word_o);
    end
  end

  // Receiver: switches between random stall patterns, and holds off for
  // a long stretch once when asked so the meter fills up.
  initial begin : receiver
    int cyc;
    int mode;
    bit held_once;
    cyc       = 0;
    mode      = 0;
    held_once = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held_once) begin
        held_once = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        if (cyc % 50 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= cyc[0];
        endcase
        cyc++;
      end
    end
  end

  initial begin : watchdog
    #(3_000_000);
    $display("level_meter_ballistics_tb: done, errors");
    $finish;
  end

  function automatic lmb_in_t mk_word(level_t p, level_t r);
    lmb_in_t w;
    w.peak_level = p;
    w.rms_level  = r;
    return w;
  endfunction

  // Mostly envelope-like tick sequences: tones, silences, decaying pulses and
  // steady levels, mixed with raw random words.
  function automatic lmb_in_t make_word();
    lmb_in_t w;
    if (env_left == 0) begin
      env_mode   = $urandom_range(0, 9);
      env_left   = $urandom_range(4, 40);
      env_target = level_t'($urandom);
    end
    env_left--;
    case (env_mode)
      0, 1, 2, 3: begin
        w.peak_level = env_target ^ level_t'($urandom_range(0, 255));
        w.rms_level  = (env_target >> 1) ^ level_t'($urandom_range(0, 127));
      end
      4, 5: w = mk_word('0, level_t'($urandom_range(0, 1)));
      6, 7: w = $urandom;
      8: begin
        w = mk_word(env_target, env_target >> 2);
        env_target = env_target >> 1;
      end
      default: w = mk_word(env_target, env_target);
    endcase
    return w;
  endfunction

  // Leaves valid high; the caller lowers it when a gap follows.
  task automatic send_word(lmb_in_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random(int n);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_word(make_word());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic put_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic write_regs(coef_t a, coef_t r, coef_t d, logic [CfgBits-1:0] t);
    put_reg(RegAttack, a);
    put_reg(RegRelease, r);
    put_reg(RegHoldDecay, d);
    put_reg(RegHoldTicks, t);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.pending() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (6) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [CfgBits-1:0] tick_data;
    sb         = new();
    hold_req   = 1'b0;
    env_mode   = 0;
    env_left   = 0;
    env_target = '0;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = RegAttack;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coefficients. The first tick is an equal level at zero; the
    // repeated full-scale peak equals the held value and must not reload.
    send_word(mk_word(16'd0, 16'd0));
    send_word(mk_word(16'hFFFF, 16'hFFFF));
    send_word(mk_word(16'hFFFF, 16'hFFFF));
    send_word(mk_word(16'd32768, 16'd1));
    send_word(mk_word(16'd0, 16'hFFFF));
    send_word(mk_word(16'd1, 16'd0));
    send_word(mk_word(16'd0, 16'd0));
    send_word(mk_word(16'd0, 16'd0));
    wait_idle();

    // All-zero coefficients; the upper data bits of the tick count are dropped,
    // so the held peak decays on the tick after capture.
    write_regs('0, '0, '0, 16'hFF00);
    send_word(mk_word(16'd40000, 16'd30000));
    send_word(mk_word(16'd0, 16'd0));
    send_word(mk_word(16'd0, 16'd0));
    send_word(mk_word(16'd40000, 16'd30000));
    send_word(mk_word(16'd40001, 16'd0));
    send_word(mk_word(16'd0, 16'd0));
    send_random(60);
    wait_idle();

    // All-ones coefficients with the longest hold. The receiver holds off
    // while a long run of words is offered.
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(mk_word(16'hFFFF, 16'hFFFF));
    send_word(mk_word(16'd0, 16'd0));
    send_word(mk_word(16'd100, 16'd65534));
    send_word(mk_word(16'd0, 16'd0));
    hold_req = 1'b1;
    repeat (60) send_word(make_word());
    send_random(40);
    wait_idle();

    write_regs(AttackReset, ReleaseReset, HoldDecayReset, {8'h00, HoldTicksReset});
    send_random(150);
    wait_idle();

    repeat (3) begin
      tick_data = CfgBits'($urandom);
      if ($urandom_range(0, 1) != 0)
        tick_data[TickBits-1:0] = TickBits'($urandom_range(0, 12));
      write_regs(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom), tick_data);
      send_random(140);
      wait_idle();
    end

    if (sb.pending() > 0) sb.errors++;
    if (sb.errors == 0)
      $display("level_meter_ballistics_tb: done, clean");
    else
      $display("level_meter_ballistics_tb: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lmb_pkg.sv
sv/lmb_ballistic.sv
sv/lmb_hold.sv
sv/level_meter_ballistics.sv
sv/lmb_checker.sv
tb/level_meter_ballistics_tb.sv
